// ===== rtl/pmc_pkg.sv =====
// Package: shared types, codes and constants for the pump mode controller.
package pmc_pkg;

    localparam int TIME_BITS = 32;
    localparam int CMP_W     = (TIME_BITS > 32) ? TIME_BITS : 32;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_LOW   = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd1000;
    localparam logic [31:0] TIMEOUT_RST   = 32'd30000;
    localparam logic [15:0] INTERVAL_RST  = 16'd1000;
    localparam logic [6:0]  THRESHOLD_RST = 7'd50;
    localparam logic        ACT_LOW_RST   = 1'b1;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_MODE   = 2'd1;
    localparam logic [1:0] ACT_REQ    = 2'd2;
    localparam logic [1:0] ACT_SAMPLE = 2'd3;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;
    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam logic [6:0] MODE_CODE_MAX = 7'd3;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ON      = 3'd1;
    localparam logic [2:0] EV_OFF     = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_BLOCKED = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] value;
    } t_in_req;

    typedef struct packed {
        logic       pump_on;
        logic       relay_level;
        logic [1:0] mode_now;
        logic [2:0] event_res;
    } t_out_res;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [31:0] safety_timeout_ms;
        logic [15:0] update_interval_ms;
        logic [6:0]  moisture_threshold;
        logic        relay_invert;
    } t_cfg;

endpackage

// ===== rtl/pmc_cfg.sv =====
// Configuration register file for the pump mode controller.
module pmc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output pmc_pkg::t_cfg                    o_cfg
);

    pmc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= pmc_pkg::DEBOUNCE_RST;
            r_cfg.safety_timeout_ms  <= pmc_pkg::TIMEOUT_RST;
            r_cfg.update_interval_ms <= pmc_pkg::INTERVAL_RST;
            r_cfg.moisture_threshold <= pmc_pkg::THRESHOLD_RST;
            r_cfg.relay_invert       <= pmc_pkg::ACT_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pmc_pkg::CFG_DEBOUNCE:  r_cfg.debounce_ms        <= i_cfg_wdata[15:0];
                pmc_pkg::CFG_TIMEOUT:   r_cfg.safety_timeout_ms  <= i_cfg_wdata[31:0];
                pmc_pkg::CFG_INTERVAL:  r_cfg.update_interval_ms <= i_cfg_wdata[15:0];
                pmc_pkg::CFG_THRESHOLD: r_cfg.moisture_threshold <= i_cfg_wdata[6:0];
                pmc_pkg::CFG_ACT_LOW:   r_cfg.relay_invert       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pmc_core.sv =====
// Controller state registers and the per-request next-state logic.
module pmc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  pmc_pkg::t_in_req  i_req,
    input  pmc_pkg::t_cfg     i_cfg,
    output pmc_pkg::t_out_res o_res
);

    localparam int TW = pmc_pkg::TIME_BITS;
    localparam int CW = pmc_pkg::CMP_W;

    logic [TW-1:0] r_clock,  n_clock;
    logic          r_run,    n_run;
    logic [1:0]    r_mode,   n_mode;
    logic [TW-1:0] r_start,  n_start;
    logic [TW-1:0] r_change, n_change;
    logic [TW-1:0] r_update, n_update;

    logic [TW-1:0] el_change;
    logic [TW-1:0] el_update;
    logic [TW-1:0] el_run;
    logic          blocked;
    logic          do_req;
    logic          want;
    logic          tmo;
    logic [2:0]    ev;

    assign el_change = r_clock - r_change;
    assign el_update = r_clock - r_update;
    assign el_run    = r_clock - r_start;
    assign blocked   = el_change < TW'(i_cfg.debounce_ms);

    always_comb begin
        n_clock  = r_clock;
        n_run    = r_run;
        n_mode   = r_mode;
        n_start  = r_start;
        n_change = r_change;
        n_update = r_update;
        do_req   = 1'b0;
        want     = 1'b0;
        tmo      = 1'b0;
        ev       = pmc_pkg::EV_NONE;

        case (i_req.action)
            pmc_pkg::ACT_TICK: begin
                n_clock = r_clock + TW'(1);
            end
            pmc_pkg::ACT_MODE: begin
                if (i_req.value <= pmc_pkg::MODE_CODE_MAX) begin
                    n_mode = i_req.value[1:0];
                    if (i_req.value[1:0] == pmc_pkg::MODE_OFF && r_run) begin
                        n_run = 1'b0;
                        ev    = pmc_pkg::EV_OFF;
                    end else if (i_req.value[1:0] == pmc_pkg::MODE_ON && !r_run) begin
                        n_run   = 1'b1;
                        n_start = r_clock;
                        ev      = pmc_pkg::EV_ON;
                    end else if (i_req.value[1:0] == pmc_pkg::MODE_AUTO &&
                                 r_mode != pmc_pkg::MODE_AUTO && r_run) begin
                        n_start = r_clock;
                    end
                end
            end
            pmc_pkg::ACT_REQ: begin
                do_req = 1'b1;
                want   = i_req.value != 7'd0;
            end
            default: begin
                if (el_update >= TW'(i_cfg.update_interval_ms)) begin
                    n_update = r_clock;
                    if (r_mode == pmc_pkg::MODE_AUTO) begin
                        if (r_run && CW'(el_run) > CW'(i_cfg.safety_timeout_ms)) begin
                            do_req = 1'b1;
                            tmo    = 1'b1;
                        end else if (!r_run && i_req.value < i_cfg.moisture_threshold) begin
                            do_req = 1'b1;
                            want   = 1'b1;
                        end else if (r_run && i_req.value > i_cfg.moisture_threshold) begin
                            do_req = 1'b1;
                        end
                    end
                end
            end
        endcase

        if (do_req) begin
            if (blocked) begin
                ev = pmc_pkg::EV_BLOCKED;
            end else if (want != r_run) begin
                n_run    = want;
                n_change = r_clock;
                if (want) begin
                    n_start = r_clock;
                    ev      = pmc_pkg::EV_ON;
                end else begin
                    ev = tmo ? pmc_pkg::EV_TIMEOUT : pmc_pkg::EV_OFF;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock  <= '0;
            r_run    <= 1'b0;
            r_mode   <= pmc_pkg::MODE_AUTO;
            r_start  <= '0;
            r_change <= '0;
            r_update <= '0;
        end else if (i_step) begin
            r_clock  <= n_clock;
            r_run    <= n_run;
            r_mode   <= n_mode;
            r_start  <= n_start;
            r_change <= n_change;
            r_update <= n_update;
        end
    end

    always_comb begin
        o_res.pump_on     = n_run;
        o_res.relay_level = i_cfg.relay_invert ? !n_run : n_run;
        o_res.mode_now    = n_mode;
        o_res.event_res   = ev;
    end

endmodule

// ===== rtl/pump_mode_controller.sv =====
// Top level: input register, controller core and result register.
// Path: a request held in the input register passes through the core into the result register on o_out_*.
// Throughput: one request per cycle; the input register takes a request whenever it is
// empty or its contents move on, so a held result stalls the input once both stages fill.
// Reset: synchronous, active low; clears both stages, state and configuration
// registers to their defaults (clock 0, pump off, auto mode).
module pump_mode_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pmc_pkg::t_in_req                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pmc_pkg::t_out_res                o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic              r_in_valid;
    pmc_pkg::t_in_req  r_in_data;
    logic              r_out_valid;
    pmc_pkg::t_out_res r_out_data;

    logic              out_free;
    logic              step;
    pmc_pkg::t_cfg     cfg;
    pmc_pkg::t_out_res res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    pmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/pmc_checker.sv =====
// Port-level assertions for the pump mode controller, bound to the top level.
module pmc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pmc_pkg::t_out_res o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ev_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == pmc_pkg::EV_ON |-> o_out_data.pump_on)
        else $error("switched-on event with pump off");

    a_ev_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res == pmc_pkg::EV_OFF ||
                        o_out_data.event_res == pmc_pkg::EV_TIMEOUT)
        |-> !o_out_data.pump_on)
        else $error("switched-off event with pump on");

    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_res == pmc_pkg::EV_NONE ||
                         o_out_data.event_res == pmc_pkg::EV_ON ||
                         o_out_data.event_res == pmc_pkg::EV_OFF ||
                         o_out_data.event_res == pmc_pkg::EV_TIMEOUT ||
                         o_out_data.event_res == pmc_pkg::EV_BLOCKED))
        else $error("undefined event code");

endmodule

bind pump_mode_controller pmc_checker u_pmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
